// File: hw/rtl/j2pa_pkg.sv
package j2pa_pkg;

  // Field widths of the request and result.
  localparam int POS_W  = 32;
  localparam int ACC_W  = 48;
  localparam int COEF_W = 48;

  // Radius squared and its normalization.
  localparam int S_W  = 2 * POS_W;
  localparam int P_W  = $clog2(S_W);
  localparam int SH_W = 8;

  // Square root, reciprocal and unit vector dividers.
  localparam int ROOT_W   = 32;
  localparam int SREM_W   = 35;
  localparam int F_STAGES = 32;
  localparam int U_W      = 31;
  localparam int G_STAGES = U_W;

  // Term datapath.
  localparam int T_W    = 30;
  localparam int A_W    = U_W + T_W;
  localparam int G2_W   = 33;
  localparam int CW_W   = 61;
  localparam int PROD_W = COEF_W + CW_W;
  localparam int PAD_W  = 16;
  localparam int EXT_W  = PROD_W + PAD_W;
  localparam int RS_W   = 9;
  localparam int RS_BASE = 108 + PAD_W;

  localparam logic [31:0] TXY_BASE  = 32'd3 << 26;
  localparam logic [31:0] TZ_BASE   = 32'd9 << 26;
  localparam logic [31:0] GREM_INIT = 32'h2000_0000;

  // Pipeline stage numbers.
  localparam int ST_E  = 4;
  localparam int ST_G0 = ST_E + F_STAGES;
  localparam int ST_H  = ST_G0 + G_STAGES;
  localparam int ST_O  = ST_H + 7;
  localparam int ST_P  = ST_O + 1;
  localparam int SHL   = ST_O - ST_E;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ACC_W-1:0] total_in_x;
    logic signed [ACC_W-1:0] total_in_y;
    logic signed [ACC_W-1:0] total_in_z;
  } in_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] j2_x;
    logic signed [ACC_W-1:0] j2_y;
    logic signed [ACC_W-1:0] j2_z;
    logic signed [ACC_W-1:0] total_out_x;
    logic signed [ACC_W-1:0] total_out_y;
    logic signed [ACC_W-1:0] total_out_z;
    logic                    zero_radius;
  } out_res_t;

  // Data that rides along with each request to the end of the pipe.
  typedef struct packed {
    logic                  zero;
    logic [2:0]            cneg;
    logic [2:0][ACC_W-1:0] tot;
  } side_t;

  // One stage of the square root and reciprocal section.
  typedef struct packed {
    logic [63:0]       m;
    logic [ROOT_W-1:0] root;
    logic [SREM_W-1:0] rem;
    logic [31:0]       dvr;
    logic [31:0]       grem;
    logic [31:0]       gq;
    logic [2:0][31:0]  num;
  } sq_st_t;

  // One stage of the unit vector section.
  typedef struct packed {
    logic [2:0][31:0]    rem;
    logic [2:0][U_W-1:0] quo;
    logic [2:0]          nb;
    logic [31:0]         isq;
    logic [31:0]         g;
    logic [63:0]         gg;
    logic [G2_W-1:0]     g2;
  } ud_st_t;

endpackage

// File: hw/rtl/j2_perturbation_acceleration.sv
// Channel | Ports                          | Handshake
// request | start, busy, in_data           | taken when start is high and busy is low
// result  | out_valid, out_data            | each result shown for a single cycle, no back pressure
// config  | cfg_valid, cfg_ready, cfg_data | written when cfg_valid and cfg_ready are high
//
// A request is taken in every cycle; busy stays low. The result passes through the
// 32-stage square root and reciprocal section and the 31-stage unit vector divider,
// followed by the multiply and shift stages. Reset clears the valid bits of every
// stage. The receiver cannot stall, so the pipe never holds: every stage moves
// forward each cycle.
module j2_perturbation_acceleration
  import j2pa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_data,
  output logic              out_valid,
  output out_res_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [COEF_W-1:0] cfg_data
);

  // Valid line and side data.
  logic               vld_r  [ST_P+1];
  side_t              side_r [ST_P];
  logic signed [SH_W-1:0] sh_r [SHL];

  logic [COEF_W-1:0] coef_r;
  logic [COEF_W-1:0] kmag;
  logic              kneg;

  logic [POS_W-1:0] pos_in [3];
  logic [POS_W-1:0] mg_in  [3];
  logic [POS_W-1:0] mg_a_r [3];
  logic [POS_W-1:0] mg_b_r [3];
  logic [POS_W-1:0] mg_c_r [3];
  logic [POS_W-1:0] mg_d_r [3];
  logic [S_W-1:0]   sq_b_r [3];
  logic [S_W-1:0]   s_c_r;
  logic [S_W-1:0]   s_d_r;
  logic [P_W-1:0]   p_d_r;
  logic [P_W-1:0]   p_nxt;

  sq_st_t e_nxt;
  sq_st_t f_src [F_STAGES];
  sq_st_t f_nxt [F_STAGES];
  sq_st_t f_r   [F_STAGES];
  logic signed [SH_W-1:0] sh_nxt;

  ud_st_t g_src [G_STAGES];
  ud_st_t g_nxt [G_STAGES];
  ud_st_t g_r   [G_STAGES];

  logic [U_W-1:0]    u_h_r  [3];
  logic [2*U_W-1:0]  pz_h_r;
  logic [G2_W-1:0]   g2_h_r;
  logic [U_W-1:0]    u_i_r  [3];
  logic [T_W-1:0]    tm_i_r [3];
  logic [2:0]        tn_i_r;
  logic [G2_W-1:0]   g2_i_r;
  logic [A_W-1:0]    a_j_r  [3];
  logic [2:0]        tn_j_r;
  logic [G2_W-1:0]   g2_j_r;
  logic [64:0]       plo_k_r [3];
  logic [61:0]       phi_k_r [3];
  logic [2:0]        tn_k_r;
  logic [CW_W-1:0]   cw_l_r [3];
  logic [2:0]        tn_l_r;
  logic [63:0]       pll_m_r [3];
  logic [60:0]       plh_m_r [3];
  logic [47:0]       phl_m_r [3];
  logic [44:0]       phh_m_r [3];
  logic [2:0]        tn_m_r;
  logic [PROD_W-1:0] p_n_r  [3];
  logic [2:0]        tn_n_r;
  logic [ACC_W-1:0]  term_o_r [3];
  logic [ACC_W-1:0]  term_nxt [3];
  logic [ACC_W-1:0]  sum_nxt  [3];

  logic [65:0]        qw;
  logic [31:0]        q;
  logic signed [32:0] txy;
  logic signed [32:0] tz;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Coefficient register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      coef_r <= cfg_data;
    end
  end

  assign kneg = coef_r[COEF_W-1];
  assign kmag = kneg ? (~coef_r + 1'b1) : coef_r;

  // Valid bits travel with the requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ST_P; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= start && !busy;
      for (int k = 1; k <= ST_P; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Magnitudes of the position.
  always_comb begin
    pos_in[0] = in_data.pos_x;
    pos_in[1] = in_data.pos_y;
    pos_in[2] = in_data.pos_z;
    for (int c = 0; c < 3; c++) begin
      mg_in[c] = pos_in[c][POS_W-1] ? (~pos_in[c] + 1'b1) : pos_in[c];
    end
  end

  // Side line: origin flag, coordinate signs and running totals.
  always_ff @(posedge clk) begin
    side_r[0].zero    <= (pos_in[0] == '0) && (pos_in[1] == '0) && (pos_in[2] == '0);
    side_r[0].cneg    <= {pos_in[2][POS_W-1], pos_in[1][POS_W-1], pos_in[0][POS_W-1]};
    side_r[0].tot[0]  <= in_data.total_in_x;
    side_r[0].tot[1]  <= in_data.total_in_y;
    side_r[0].tot[2]  <= in_data.total_in_z;
    for (int k = 1; k < ST_P; k++) side_r[k] <= side_r[k-1];
  end

  // Squares, their sum and the leading one of the sum.
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < S_W; i++) begin
      if (s_c_r[i]) p_nxt = P_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      mg_a_r[c] <= mg_in[c];
      sq_b_r[c] <= S_W'(mg_a_r[c]) * S_W'(mg_a_r[c]);
      mg_b_r[c] <= mg_a_r[c];
      mg_c_r[c] <= mg_b_r[c];
      mg_d_r[c] <= mg_c_r[c];
    end
    s_c_r <= sq_b_r[0] + sq_b_r[1] + sq_b_r[2];
    s_d_r <= s_c_r;
    p_d_r <= p_nxt;
  end

  // Even normalizing shift: radius squared to [2^62, 2^64), coordinates by half.
  always_comb begin
    logic signed [SH_W-1:0] sh_raw;
    logic signed [SH_W-1:0] h;
    logic [SH_W-1:0]        mamt;
    logic [SH_W-1:0]        namt;
    logic [S_W+63:0]        mext;
    logic [POS_W+31:0]      next;
    sh_raw = SH_W'(63) - SH_W'(p_d_r);
    sh_nxt = sh_raw[0] ? (sh_raw - 1'b1) : sh_raw;
    h      = sh_nxt >>> 1;
    mamt   = SH_W'(64) - sh_nxt;
    namt   = SH_W'(32) - h;
    mext   = {s_d_r, 64'b0} >> mamt;
    e_nxt.m    = mext[63:0];
    e_nxt.root = '0;
    e_nxt.rem  = '0;
    e_nxt.dvr  = mext[63:32];
    e_nxt.grem = GREM_INIT;
    e_nxt.gq   = '0;
    for (int c = 0; c < 3; c++) begin
      next = {mg_d_r[c], 32'b0} >> namt;
      e_nxt.num[c] = next[31:0];
    end
  end

  // Square root two bits a stage, reciprocal one quotient bit a stage.
  always_comb begin
    sq_st_t            prv;
    logic [SREM_W-1:0] remx;
    logic [SREM_W-1:0] trial;
    logic [32:0]       gremx;
    logic [32:0]       gdiff;
    f_src[0] = e_nxt;
    for (int k = 1; k < F_STAGES; k++) f_src[k] = f_r[k-1];
    for (int k = 0; k < F_STAGES; k++) begin
      prv   = f_src[k];
      remx  = {prv.rem[SREM_W-3:0], prv.m[63-2*k -: 2]};
      trial = {1'b0, prv.root, 2'b01};
      f_nxt[k] = prv;
      if (remx >= trial) begin
        f_nxt[k].rem  = remx - trial;
        f_nxt[k].root = {prv.root[ROOT_W-2:0], 1'b1};
      end else begin
        f_nxt[k].rem  = remx;
        f_nxt[k].root = {prv.root[ROOT_W-2:0], 1'b0};
      end
      gremx = {prv.grem, 1'b0};
      gdiff = gremx - {1'b0, prv.dvr};
      if (gremx >= {1'b0, prv.dvr}) begin
        f_nxt[k].grem = gdiff[31:0];
        f_nxt[k].gq   = {prv.gq[30:0], 1'b1};
      end else begin
        f_nxt[k].grem = gremx[31:0];
        f_nxt[k].gq   = {prv.gq[30:0], 1'b0};
      end
    end
  end

  // The first stage of this section takes the even shift into the shift line.
  always_ff @(posedge clk) begin
    for (int k = 0; k < F_STAGES; k++) f_r[k] <= f_nxt[k];
    sh_r[0] <= sh_nxt;
    for (int k = 1; k < SHL; k++) sh_r[k] <= sh_r[k-1];
  end

  // Unit vector dividers, one quotient bit a stage; g squared on the side.
  always_comb begin
    ud_st_t      prv;
    logic [32:0] remx;
    logic [32:0] diff;
    for (int c = 0; c < 3; c++) begin
      g_src[0].rem[c] = {1'b0, f_r[F_STAGES-1].num[c][31:1]};
      g_src[0].nb[c]  = f_r[F_STAGES-1].num[c][0];
    end
    g_src[0].quo = '0;
    g_src[0].isq = f_r[F_STAGES-1].root;
    g_src[0].g   = f_r[F_STAGES-1].gq;
    g_src[0].gg  = '0;
    g_src[0].g2  = '0;
    for (int j = 1; j < G_STAGES; j++) g_src[j] = g_r[j-1];
    for (int j = 0; j < G_STAGES; j++) begin
      prv = g_src[j];
      g_nxt[j] = prv;
      if (j == 0) begin
        g_nxt[j].gg = 64'(prv.g) * 64'(prv.g);
      end
      if (j == 1) begin
        g_nxt[j].g2 = prv.gg[62:30];
      end
      for (int c = 0; c < 3; c++) begin
        remx = {prv.rem[c], (j == 0) ? prv.nb[c] : 1'b0};
        diff = remx - {1'b0, prv.isq};
        if (remx >= {1'b0, prv.isq}) begin
          g_nxt[j].rem[c] = diff[31:0];
          g_nxt[j].quo[c] = {prv.quo[c][U_W-2:0], 1'b1};
        end else begin
          g_nxt[j].rem[c] = remx[31:0];
          g_nxt[j].quo[c] = {prv.quo[c][U_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < G_STAGES; j++) g_r[j] <= g_nxt[j];
  end

  // Bracket factors t = 3 - 15 uz^2 and t = 9 - 15 uz^2 in Q26.
  always_comb begin
    qw  = {pz_h_r, 4'b0} - 66'(pz_h_r);
    q   = qw[65:34];
    txy = $signed({1'b0, TXY_BASE}) - $signed({1'b0, q});
    tz  = $signed({1'b0, TZ_BASE}) - $signed({1'b0, q});
  end

  // Multiply chain: u times t, times g2, times the coefficient.
  always_ff @(posedge clk) begin
    logic [32:0] txm;
    logic [32:0] tzm;
    logic [62:0] cw;
    txm = txy[32] ? 33'(-txy) : 33'(txy);
    tzm = tz[32] ? 33'(-tz) : 33'(tz);
    for (int c = 0; c < 3; c++) u_h_r[c] <= g_r[G_STAGES-1].quo[c];
    pz_h_r <= 62'(g_r[G_STAGES-1].quo[2]) * 62'(g_r[G_STAGES-1].quo[2]);
    g2_h_r <= g_r[G_STAGES-1].g2;

    for (int c = 0; c < 3; c++) u_i_r[c] <= u_h_r[c];
    tm_i_r[0] <= txm[T_W-1:0];
    tm_i_r[1] <= txm[T_W-1:0];
    tm_i_r[2] <= tzm[T_W-1:0];
    tn_i_r    <= {tz[32], txy[32], txy[32]};
    g2_i_r    <= g2_h_r;

    for (int c = 0; c < 3; c++) begin
      a_j_r[c]   <= A_W'(u_i_r[c]) * A_W'(tm_i_r[c]);
      plo_k_r[c] <= 65'(a_j_r[c][31:0]) * 65'(g2_j_r);
      phi_k_r[c] <= 62'(a_j_r[c][A_W-1:32]) * 62'(g2_j_r);
      cw = 63'(phi_k_r[c]) + 63'(plo_k_r[c][64:32]);
      cw_l_r[c]  <= cw[CW_W-1:0];
      pll_m_r[c] <= 64'(kmag[31:0]) * 64'(cw_l_r[c][31:0]);
      plh_m_r[c] <= 61'(kmag[31:0]) * 61'(cw_l_r[c][CW_W-1:32]);
      phl_m_r[c] <= 48'(kmag[COEF_W-1:32]) * 48'(cw_l_r[c][31:0]);
      phh_m_r[c] <= 45'(kmag[COEF_W-1:32]) * 45'(cw_l_r[c][CW_W-1:32]);
      p_n_r[c]   <= PROD_W'(pll_m_r[c]) + (PROD_W'(plh_m_r[c]) << 32)
                  + (PROD_W'(phl_m_r[c]) << 32) + (PROD_W'(phh_m_r[c]) << 64);
    end
    g2_j_r <= g2_i_r;
    tn_j_r <= tn_i_r;
    tn_k_r <= tn_j_r;
    tn_l_r <= tn_k_r;
    tn_m_r <= tn_l_r;
    tn_n_r <= tn_m_r;
  end

  // Scale by 2^(2 sh - 108), saturate and apply the sign; a zero radius gives a zero term.
  always_comb begin
    logic signed [RS_W:0] rs_s;
    logic [RS_W-1:0]      rs;
    logic [EXT_W-1:0]     v;
    logic                 ovf;
    logic                 neg;
    logic [ACC_W-1:0]     mag;
    rs_s = (RS_W+1)'(RS_BASE) - ({{(RS_W+1-SH_W){sh_r[SHL-1][SH_W-1]}}, sh_r[SHL-1]} <<< 1);
    rs   = rs_s[RS_W-1:0];
    for (int c = 0; c < 3; c++) begin
      v   = {p_n_r[c], {PAD_W{1'b0}}} >> rs;
      ovf = |v[EXT_W-1:ACC_W-1];
      neg = kneg ^ side_r[ST_O-1].cneg[c] ^ tn_n_r[c];
      mag = {1'b0, v[ACC_W-2:0]};
      if (side_r[ST_O-1].zero) begin
        term_nxt[c] = '0;
      end else if (ovf) begin
        term_nxt[c] = neg ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        term_nxt[c] = neg ? (~mag + 1'b1) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) term_o_r[c] <= term_nxt[c];
  end

  // Saturating add to the running total.
  always_comb begin
    logic [ACC_W:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum = {side_r[ST_P-1].tot[c][ACC_W-1], side_r[ST_P-1].tot[c]}
          + {term_o_r[c][ACC_W-1], term_o_r[c]};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        sum_nxt[c] = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        sum_nxt[c] = sum[ACC_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_data.j2_x        <= term_o_r[0];
    out_data.j2_y        <= term_o_r[1];
    out_data.j2_z        <= term_o_r[2];
    out_data.total_out_x <= sum_nxt[0];
    out_data.total_out_y <= sum_nxt[1];
    out_data.total_out_z <= sum_nxt[2];
    out_data.zero_radius <= side_r[ST_P-1].zero;
  end

  assign out_valid = vld_r[ST_P];

endmodule
